// File: sv/ising_pkg.sv
// Shared constants and register codes for the Ising Metropolis update block.
package ising_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam int SIDE_W    = 7;
    localparam int THR_W     = 31;
    localparam int COORD_W   = 6;
    localparam int CLS_W     = 3;
    localparam int CNT_OUT_W = 13;
    localparam int NUM_CLASS = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [THR_W-1:0]  THR_FULL   = 31'h7FFF_FFFF;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR4 = 3'd5;

endpackage

// File: sv/ising_row_mem.sv
// Single-port lattice row memory with registered read data.
module ising_row_mem #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ising_metropolis_update_top.sv
// Metropolis update of a toroidal 2D Ising lattice held as one row of spins per memory word.
// After reset the lattice memory is set to all up, one row per cycle; the input is not
// ready during that pass, and configuration writes are taken meanwhile.
// For an in-range site the single-port row memory is read for the row above, the row
// below and the site's own row, the class is formed and compared with its threshold,
// and the row is written back if the spin flips. A site outside the side in use passes
// through the hold state. The next input is taken while a result still waits on the output
// register; an in-range result waits in the hold state only if the previous one is pending.
module ising_metropolis_update_top #(
    parameter int MAX_SIDE = ising_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ising_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ising_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] site_row, [11:6] site_col, [42:12] random_value, [47:43] zero
    input  logic [ising_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] flipped, [1] new_spin, [4:2] energy_class, [17:5] down_count, [23:18] zero
    output logic [ising_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] out_of_range
    output logic                                m_axis_tuser
);

    import ising_pkg::*;

    localparam int ROW_W  = $clog2(MAX_SIDE);
    localparam int SU_W   = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SU_W > SIDE_W) ? SU_W : SIDE_W;
    localparam int NCELLS = MAX_SIDE * MAX_SIDE;
    localparam int DW     = $clog2(NCELLS + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD_DN  = 3'd2;
    localparam logic [2:0] S_RD_MID = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // configuration
    logic [SIDE_W-1:0] r_side;
    logic [THR_W-1:0]  r_thr [NUM_CLASS];

    // sequencer and item state
    logic [2:0]          r_state, n_state;
    logic [ROW_W-1:0]    r_clr;
    logic [ROW_W-1:0]    r_row, r_col, r_dn, r_lf, r_rt;
    logic [THR_W-1:0]    r_rnd;
    logic [1:0]          r_ups;
    logic                r_own, r_flip, r_oor;
    logic [CLS_W-1:0]    r_cls;
    logic [MAX_SIDE-1:0] r_wrow;
    logic [DW-1:0]       r_down;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    // memory port
    logic                w_we;
    logic [ROW_W-1:0]    w_addr;
    logic [MAX_SIDE-1:0] w_wdata;
    logic [MAX_SIDE-1:0] w_rdata;

    // input decode and wrap
    logic [CW-1:0]      w_side_ext, w_s, w_in_row, w_in_col;
    logic [CW-1:0]      w_up_c, w_dn_c, w_lf_c, w_rt_c;
    logic               w_in_oor;
    logic               w_accept;
    logic               w_out_free;

    // evaluation
    logic [CLS_W-1:0]   w_ups, w_cls;
    logic [THR_W-1:0]   w_thr;
    logic               w_own, w_flip;
    logic [MAX_SIDE-1:0] w_mask;

    assign w_side_ext = CW'(r_side);
    assign w_s        = (w_side_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : w_side_ext;
    assign w_in_row   = CW'(s_axis_tdata[COORD_W-1:0]);
    assign w_in_col   = CW'(s_axis_tdata[2*COORD_W-1:COORD_W]);
    assign w_in_oor   = (w_in_row >= w_s) || (w_in_col >= w_s);
    assign w_up_c     = (w_in_row == '0) ? w_s - CW'(1) : w_in_row - CW'(1);
    assign w_dn_c     = (w_in_row + CW'(1) == w_s) ? '0 : w_in_row + CW'(1);
    assign w_lf_c     = (w_in_col == '0) ? w_s - CW'(1) : w_in_col - CW'(1);
    assign w_rt_c     = (w_in_col + CW'(1) == w_s) ? '0 : w_in_col + CW'(1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // own row comes back in S_EVAL: site, left and right neighbors
    assign w_own  = w_rdata[r_col];
    assign w_ups  = CLS_W'(r_ups) + CLS_W'(w_rdata[r_lf]) + CLS_W'(w_rdata[r_rt]);
    assign w_cls  = w_own ? w_ups : CLS_W'(4) - w_ups;

    always_comb begin
        case (w_cls)
            3'd0:    w_thr = r_thr[0];
            3'd1:    w_thr = r_thr[1];
            3'd2:    w_thr = r_thr[2];
            3'd3:    w_thr = r_thr[3];
            3'd4:    w_thr = r_thr[4];
            default: w_thr = '0;
        endcase
    end

    assign w_flip = (r_rnd < w_thr);
    assign w_mask = MAX_SIDE'(1) << r_col;

    // memory port mux
    always_comb begin
        w_we    = 1'b0;
        w_addr  = ROW_W'(w_up_c);
        w_wdata = r_wrow ^ w_mask;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr;
                w_wdata = '1;
            end
            S_IDLE:   w_addr = ROW_W'(w_up_c);
            S_RD_DN:  w_addr = r_dn;
            S_RD_MID: w_addr = r_row;
            S_WRITE: begin
                w_we   = r_flip;
                w_addr = r_row;
            end
            default:  w_addr = r_row;
        endcase
    end

    ising_row_mem #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            for (int k = 0; k < NUM_CLASS; k++) begin
                r_thr[k] <= THR_FULL;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIDE: r_side   <= i_cfg_data[SIDE_W-1:0];
                CFG_THR0: r_thr[0] <= i_cfg_data;
                CFG_THR1: r_thr[1] <= i_cfg_data;
                CFG_THR2: r_thr[2] <= i_cfg_data;
                CFG_THR3: r_thr[3] <= i_cfg_data;
                CFG_THR4: r_thr[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == ROW_W'(MAX_SIDE - 1)) n_state = S_IDLE;
            S_IDLE:   if (w_accept) n_state = w_in_oor ? S_DONE : S_RD_DN;
            S_RD_DN:  n_state = S_RD_MID;
            S_RD_MID: n_state = S_EVAL;
            S_EVAL:   n_state = S_WRITE;
            S_WRITE:  n_state = w_out_free ? S_IDLE : S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_down  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ROW_W'(1);
            end
            if (r_state == S_WRITE && r_flip) begin
                if (r_own) begin
                    r_down <= r_down + DW'(1);
                end else begin
                    r_down <= r_down - DW'(1);
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_row <= ROW_W'(w_in_row);
                r_col <= ROW_W'(w_in_col);
                r_dn  <= ROW_W'(w_dn_c);
                r_lf  <= ROW_W'(w_lf_c);
                r_rt  <= ROW_W'(w_rt_c);
                r_rnd <= s_axis_tdata[2*COORD_W+THR_W-1:2*COORD_W];
                r_oor <= w_in_oor;
                r_own <= 1'b0;
                r_flip <= 1'b0;
                r_cls <= '0;
            end
            S_RD_DN:  r_ups <= {1'b0, w_rdata[r_col]};
            S_RD_MID: r_ups <= r_ups + {1'b0, w_rdata[r_col]};
            S_EVAL: begin
                r_own  <= w_own;
                r_flip <= w_flip;
                r_cls  <= w_cls;
                r_wrow <= w_rdata;
            end
            default: ;
        endcase
    end

    // output register; down_count is taken after the write-back update
    logic w_load;
    logic [DW-1:0] w_down_next;

    assign w_load      = w_out_free && (r_state == S_WRITE || r_state == S_DONE);
    assign w_down_next = (r_state == S_WRITE && r_flip) ?
                         (r_own ? r_down + DW'(1) : r_down - DW'(1)) : r_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {(OUT_TDATA_W - CNT_OUT_W - CLS_W - 2)'(0),
                           CNT_OUT_W'(w_down_next),
                           r_cls,
                           r_own ^ r_flip,
                           r_flip};
            r_out_user <= r_oor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    a_down_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_down <= DW'(NCELLS))
        else $error("down count exceeds lattice size");

    a_flip_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_flip) |=> (r_down != $past(r_down)))
        else $error("flip did not change down count");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_WRITE))
        else $error("memory write outside clear or write-back");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_cls <= CLS_W'(4) && !r_oor))
        else $error("bad class or out-of-range site reached write-back");

    a_oor_noflip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[0] == 1'b0))
        else $error("out-of-range result reports a flip");
`endif

endmodule

// File: tb/sv/ising_metropolis_update_top_tb.sv
// Self-checking testbench for the Ising Metropolis update block: directed table, then random phases.
module ising_metropolis_update_top_tb;
    import ising_pkg::*;

    localparam int MAX_SIDE   = MAX_SIDE_DEF;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 155;
    localparam int SETTLE     = 8;
    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

    typedef struct packed {
        logic        flipped;
        logic        new_spin;
        logic [2:0]  cls;
        logic [12:0] downs;
        logic        oor;
    } t_site_result;

    typedef enum bit {STEP_ITEM, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [THR_W-1:0]     value;
        logic [5:0]           row;
        logic [5:0]           col;
        logic [THR_W-1:0]     rnd;
        bit                   typed;
        t_site_result         want;
    } t_dir_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [5:0] site_row, [11:6] site_col, [42:12] random_value, [47:43] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] flipped, [1] new_spin, [4:2] energy_class, [17:5] down_count, [23:18] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] out_of_range
    logic                   m_axis_tuser;

    ising_metropolis_update_top #(.MAX_SIDE(MAX_SIDE)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // lattice model
    bit               spin_mem [MAX_SIDE*MAX_SIDE];
    int               down_total;
    logic [SIDE_W-1:0] side_reg;
    logic [THR_W-1:0] accept_thr [NUM_CLASS];

    t_site_result pending_updates [$];
    t_dir_step    dir_steps [$];
    bit           idle_on = 1'b1;
    int           mismatches = 0;
    int           n_sent = 0;
    int           n_results = 0;
    int           n_flips = 0;
    int           n_off = 0;

    function automatic int side_eff();
        return (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
    endfunction

    function automatic t_site_result metropolis_step(logic [5:0] row, logic [5:0] col,
                                                     logic [THR_W-1:0] rnd);
        t_site_result res;
        int s, r, c, up_r, dn_r, lf_c, rt_c, ups, cls;
        bit own;
        s = side_eff();
        r = int'(row);
        c = int'(col);
        res = '0;
        res.downs = down_total[12:0];
        if (r >= s || c >= s) begin
            res.oor = 1'b1;
            return res;
        end
        // toroidal neighbors
        up_r = (r == 0) ? s - 1 : r - 1;
        dn_r = (r + 1 == s) ? 0 : r + 1;
        lf_c = (c == 0) ? s - 1 : c - 1;
        rt_c = (c + 1 == s) ? 0 : c + 1;
        ups = int'(spin_mem[r*MAX_SIDE + lf_c]) + int'(spin_mem[r*MAX_SIDE + rt_c])
            + int'(spin_mem[up_r*MAX_SIDE + c]) + int'(spin_mem[dn_r*MAX_SIDE + c]);
        own = spin_mem[r*MAX_SIDE + c];
        cls = own ? ups : 4 - ups;
        if (rnd < accept_thr[cls]) begin
            own = ~own;
            spin_mem[r*MAX_SIDE + c] = own;
            if (own) down_total--;
            else down_total++;
            res.flipped = 1'b1;
        end
        res.new_spin = own;
        res.cls = cls[2:0];
        res.downs = down_total[12:0];
        return res;
    endfunction

    function automatic void add_item(logic [5:0] row, logic [5:0] col, logic [THR_W-1:0] rnd);
        t_dir_step st;
        st = '{STEP_ITEM, '0, '0, row, col, rnd, 1'b0, '0};
        dir_steps = {dir_steps, st};
    endfunction

    function automatic void add_typed(logic [5:0] row, logic [5:0] col, logic [THR_W-1:0] rnd,
                                      t_site_result want);
        t_dir_step st;
        st = '{STEP_ITEM, '0, '0, row, col, rnd, 1'b1, want};
        dir_steps = {dir_steps, st};
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
        t_dir_step st;
        st = '{STEP_CFG, idx, value, '0, '0, '0, 1'b0, '0};
        dir_steps = {dir_steps, st};
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return THR_FULL;
            default: return THR_W'($urandom_range(0, THR_FULL));
        endcase
    endfunction

    task automatic wait_results_done();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // register writes happen only with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SIDE: side_reg = value[SIDE_W-1:0];
            CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3, CFG_THR4:
                accept_thr[idx - CFG_THR0] = value;
            default: ;
        endcase
    endtask

    task automatic send_site(logic [5:0] row, logic [5:0] col, logic [THR_W-1:0] rnd,
                             bit typed, t_site_result typed_res);
        int gap;
        t_site_result res;
        gap = idle_on ? int'($urandom_range(0, 6)) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {5'd0, rnd, col, row};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        res = metropolis_step(row, col, rnd);
        pending_updates = {pending_updates, (typed ? typed_res : res)};
        n_sent++;
    endtask

    function automatic void cmp_field(string name, logic [12:0] want, logic [12:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_update(t_site_result got);
        t_site_result want;
        n_results++;
        if (got.flipped === 1'b1) n_flips++;
        if (got.oor === 1'b1) n_off++;
        if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            mismatches++;
            return;
        end
        want = pending_updates.pop_front();
        cmp_field("flipped", 13'(want.flipped), 13'(got.flipped));
        cmp_field("new_spin", 13'(want.new_spin), 13'(got.new_spin));
        cmp_field("energy_class", 13'(want.cls), 13'(got.cls));
        cmp_field("down_count", want.downs, got.downs);
        cmp_field("out_of_range", 13'(want.oor), 13'(got.oor));
    endfunction

    // result side: random back-pressure except in the no-gap phases, check every transfer
    initial begin
        int stall;
        t_site_result got;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? int'($urandom_range(0, 6)) : 0;
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
            got.flipped  = m_axis_tdata[0];
            got.new_spin = m_axis_tdata[1];
            got.cls      = m_axis_tdata[4:2];
            got.downs    = m_axis_tdata[17:5];
            got.oor      = m_axis_tuser;
            check_update(got);
        end
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [THR_W-1:0] phase_side [NUM_PHASES];
        int p, n, k, s;
        logic [5:0] row, col;
        logic [THR_W-1:0] rnd, t;

        phase_side = '{64, 16, 2, 5, 37, 100, 64, 1, 63, 3};

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        foreach (spin_mem[i]) spin_mem[i] = 1'b1;
        down_total = 0;
        side_reg = SIDE_RESET;
        foreach (accept_thr[i]) accept_thr[i] = THR_FULL;

        // fresh lattice: all up, every threshold at max
        add_typed(0, 0, 0, '{1'b1, 1'b0, 3'd4, 13'd1, 1'b0});
        add_typed(0, 0, THR_FULL, '{1'b0, 1'b0, 3'd0, 13'd1, 1'b0});
        add_typed(63, 63, 0, '{1'b1, 1'b0, 3'd4, 13'd2, 1'b0});
        add_cfg(CFG_THR0, 0);
        add_cfg(CFG_THR4, 0);
        add_typed(32, 32, 0, '{1'b0, 1'b1, 3'd4, 13'd2, 1'b0});
        // side zero: nothing is on the lattice
        add_cfg(CFG_SIDE, 0);
        add_typed(0, 0, 0, '{1'b0, 1'b0, 3'd0, 13'd2, 1'b1});
        add_typed(63, 63, THR_FULL, '{1'b0, 1'b0, 3'd0, 13'd2, 1'b1});
        // side one: the site is its own neighbor four times
        add_cfg(CFG_SIDE, 1);
        add_item(0, 0, 0);
        add_typed(0, 1, 0, '{1'b0, 1'b0, 3'd0, 13'd2, 1'b1});
        add_typed(1, 0, 0, '{1'b0, 1'b0, 3'd0, 13'd2, 1'b1});
        add_cfg(CFG_THR4, THR_FULL);
        add_item(0, 0, 0);
        add_cfg(CFG_SIDE, 2);
        add_item(1, 1, 0);
        add_item(0, 1, 100);
        add_item(2, 0, 0);
        add_item(1, 2, THR_FULL);
        // sides past the lattice size saturate
        add_cfg(CFG_SIDE, 127);
        add_item(63, 0, THR_FULL - 1);
        add_item(0, 63, 0);
        add_cfg(CFG_SIDE, 65);
        add_item(40, 63, 1);
        add_item(31, 42, 31'h4000_0000);
        add_cfg(CFG_THR1, 1000);
        add_cfg(CFG_THR2, 0);
        add_cfg(CFG_THR3, THR_FULL);
        add_cfg(CFG_UNUSED, 123);
        add_cfg(CFG_THR0, THR_FULL);
        // small side with old flips left outside it
        add_cfg(CFG_SIDE, 3);
        add_item(2, 2, 999);
        add_item(2, 2, 1000);
        add_item(0, 0, 0);
        add_item(3, 3, 0);
        add_cfg(CFG_SIDE, 64);
        add_item(62, 1, THR_FULL);
        add_item(21, 42, 31'h2AAA_AAAA);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_CFG)
                write_reg(dir_steps[i].idx, dir_steps[i].value);
            else
                send_site(dir_steps[i].row, dir_steps[i].col, dir_steps[i].rnd,
                          dir_steps[i].typed, dir_steps[i].want);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_SIDE, phase_side[p]);
            // first phase flips freely to scramble the whole lattice
            for (k = 0; k < NUM_CLASS; k++)
                write_reg(CFG_THR0 + CFG_IDX_W'(k), (p == 0) ? THR_FULL : pick_threshold());
            idle_on = (p % 4 != 3);
            s = side_eff();
            for (n = 0; n < PHASE_LEN; n++) begin
                if (n == 60) wait_results_done();
                if (s == 0 || (s < MAX_SIDE && $urandom_range(0, 9) == 0)) begin
                    row = 6'($urandom_range(0, 63));
                    col = 6'($urandom_range(0, 63));
                    if (s > 0) begin
                        if ($urandom_range(0, 1) == 1) row = 6'($urandom_range(s, 63));
                        else col = 6'($urandom_range(s, 63));
                    end
                end else begin
                    row = 6'($urandom_range(0, s - 1));
                    col = 6'($urandom_range(0, s - 1));
                end
                // land on and just below thresholds to hit the strict compare
                t = accept_thr[$urandom_range(0, NUM_CLASS - 1)];
                case ($urandom_range(0, 9))
                    0: rnd = t;
                    1: rnd = (t == 0) ? t : t - 1;
                    2: rnd = '0;
                    3: rnd = THR_FULL;
                    default: rnd = THR_W'($urandom_range(0, THR_FULL));
                endcase
                send_site(row, col, rnd, 1'b0, '0);
            end
        end

        idle_on = 1'b1;
        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_updates.size() != 0) begin
            $display("%0t: %0d expected updates never came out", $time, pending_updates.size());
            mismatches++;
        end

        $display("Sent %0d site updates over %0d random lattice settings plus a directed table;",
                 n_sent, NUM_PHASES);
        $display("saw %0d results, %0d flips, %0d off-lattice sites, final down count %0d",
                 n_results, n_flips, n_off, down_total);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
sv/ising_pkg.sv
sv/ising_row_mem.sv
sv/ising_metropolis_update_top.sv
tb/sv/ising_metropolis_update_top_tb.sv
